// ----- src/assert_macros.svh -----
// Assertion helpers included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, masked while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
	else $error("assertion failed");

// Condition that must never be true on a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	`ASSERT_CLK(label, clk, rst_n, !(cond))

`endif

// ----- src/slp_pkg.sv -----
// -----------------------------------------------------------------------------
// slp_pkg
// Constants, result type and frame classification for the SLIP deframer.
// -----------------------------------------------------------------------------
`default_nettype none

package slp_pkg;

	localparam int MTU          = 1280;
	localparam int IPV6_MIN_LEN = 40;
	localparam int IPV6_VERSION = 6;

	// count must hold MTU+1
	localparam int CNT_W = $clog2(MTU + 2);
	localparam int IDX_W = 11;

	localparam logic [7:0] CH_END      = 8'hC0;
	localparam logic [7:0] CH_ESC      = 8'hDB;
	localparam logic [7:0] CH_ESC_END  = 8'hDC;
	localparam logic [7:0] CH_ESC_ESC  = 8'hDD;
	localparam logic [7:0] TYPE_IPV6   = 8'h01;
	localparam logic [7:0] TYPE_STATUS = 8'h10;

	localparam logic [1:0] KIND_DATA   = 2'd0;
	localparam logic [1:0] KIND_COMMIT = 2'd1;
	localparam logic [1:0] KIND_ABORT  = 2'd2;

	localparam logic [1:0] CLS_IPV6_OK  = 2'd0;
	localparam logic [1:0] CLS_IPV6_BAD = 2'd1;
	localparam logic [1:0] CLS_STATUS   = 2'd2;
	localparam logic [1:0] CLS_UNKNOWN  = 2'd3;

	localparam logic [1:0] CAUSE_NONE     = 2'd0;
	localparam logic [1:0] CAUSE_OVERFLOW = 2'd1;
	localparam logic [1:0] CAUSE_BAD_ESC  = 2'd2;

	localparam logic [CNT_W-1:0] CNT_MAX     = CNT_W'(MTU + 1);
	localparam logic [CNT_W-1:0] CNT_IPV6_LO = CNT_W'(IPV6_MIN_LEN + 1);

	typedef struct packed {
		logic [1:0]       kind;
		logic [7:0]       data;
		logic [IDX_W-1:0] idx;
		logic [IDX_W-1:0] len;
		logic [1:0]       cls;
		logic [1:0]       cause;
	} res_t;

	// frame length includes the type byte
	function automatic logic [1:0] classify(input logic [7:0] type_b,
			input logic [7:0] ver_b, input logic [CNT_W-1:0] cnt);
		logic len_ok;
		len_ok = (cnt >= CNT_IPV6_LO) && (cnt <= CNT_MAX);
		if (type_b == TYPE_IPV6) begin
			if (len_ok && ver_b[7:4] == 4'(IPV6_VERSION))
				return CLS_IPV6_OK;
			return CLS_IPV6_BAD;
		end
		if (type_b == TYPE_STATUS)
			return CLS_STATUS;
		return CLS_UNKNOWN;
	endfunction

endpackage

`default_nettype wire

// ----- src/slp_decode.sv -----
// -----------------------------------------------------------------------------
// slp_decode
// Per-byte SLIP unescape, frame state tracking and result formation.
// -----------------------------------------------------------------------------
`default_nettype none

module slp_decode import slp_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       go,
	input  wire logic [7:0] byte_s1,
	output logic            res_v,
	output res_t            res
);

	logic             esc_q, esc_d;
	logic             poison_q, poison_d;
	logic [1:0]       cause_q, cause_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [7:0]       type_q, type_d;
	logic [7:0]       ver_q, ver_d;

	always_comb begin
		logic       ok;
		logic [7:0] dec;
		ok       = 1'b0;
		dec      = byte_s1;
		esc_d    = esc_q;
		poison_d = poison_q;
		cause_d  = cause_q;
		cnt_d    = cnt_q;
		type_d   = type_q;
		ver_d    = ver_q;
		res_v    = 1'b0;
		res      = '0;
		if (byte_s1 == CH_END) begin
			if (poison_q) begin
				res_v     = 1'b1;
				res.kind  = KIND_ABORT;
				res.cause = cause_q;
			end else if (cnt_q != '0) begin
				res_v    = 1'b1;
				res.kind = KIND_COMMIT;
				res.len  = IDX_W'(cnt_q);
				res.cls  = classify(type_q, ver_q, cnt_q);
			end
			esc_d    = 1'b0;
			poison_d = 1'b0;
			cause_d  = CAUSE_NONE;
			cnt_d    = '0;
			type_d   = '0;
			ver_d    = '0;
		end else if (!poison_q) begin
			if (esc_q) begin
				esc_d = 1'b0;
				if (byte_s1 == CH_ESC_END) begin
					dec = CH_END;
					ok  = 1'b1;
				end else if (byte_s1 == CH_ESC_ESC) begin
					dec = CH_ESC;
					ok  = 1'b1;
				end else begin
					poison_d = 1'b1;
					cause_d  = CAUSE_BAD_ESC;
				end
			end else if (byte_s1 == CH_ESC) begin
				esc_d = 1'b1;
			end else begin
				ok = 1'b1;
			end
			if (ok) begin
				if (cnt_q == CNT_MAX) begin
					// byte beyond MTU+1 is dropped and kills the frame
					poison_d = 1'b1;
					cause_d  = CAUSE_OVERFLOW;
				end else begin
					res_v    = 1'b1;
					res.kind = KIND_DATA;
					res.data = dec;
					res.idx  = IDX_W'(cnt_q);
					if (cnt_q == CNT_W'(0))
						type_d = dec;
					if (cnt_q == CNT_W'(1))
						ver_d = dec;
					cnt_d = CNT_W'(cnt_q + 1'b1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q    <= 1'b0;
			poison_q <= 1'b0;
			cause_q  <= CAUSE_NONE;
			cnt_q    <= '0;
			type_q   <= '0;
			ver_q    <= '0;
		end else if (go) begin
			esc_q    <= esc_d;
			poison_q <= poison_d;
			cause_q  <= cause_d;
			cnt_q    <= cnt_d;
			type_q   <= type_d;
			ver_q    <= ver_d;
		end
	end

endmodule

`default_nettype wire

// ----- src/slp_out_reg.sv -----
// -----------------------------------------------------------------------------
// slp_out_reg
// Result register: holds one result until the downstream transfer completes.
// -----------------------------------------------------------------------------
`default_nettype none

module slp_out_reg import slp_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic load,
	input  wire logic res_v,
	input  res_t      res,
	output logic      out_valid,
	output res_t      out_res
);

	logic valid_q;
	res_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (load)
			valid_q <= res_v;
	end

	always_ff @(posedge clk) begin
		if (load && res_v)
			res_q <= res;
	end

	assign out_valid = valid_q;
	assign out_res   = res_q;

endmodule

`default_nettype wire

// ----- src/slip_deframer_with_frame_check.sv -----
// SLIP deframer with frame check.
// Input channel: rx_valid / rx_stall / rx_byte, one raw serial byte per transfer.
// Result channel: res_valid / res_stall and the result fields. out_kind tells
// a decoded data byte (with data_byte, byte_index), a frame commit (with
// frame_length, frame_class) or a frame abort (with abort_cause).
// Data bytes are sent as soon as they are decoded; the receiver must buffer
// them until the commit and drop them on an abort.
// Throughput: one byte per cycle unless res_stall holds a pending result; the
// input register and the result register are the only stages, and the per-byte
// decision is a single pass between them. A result is loaded into the result
// register from its byte in the input register. Bytes that produce no result
// (ESC, END of an empty frame, bytes of a poisoned frame) still pass the decoder.
// Reset clears the frame state and both valid flags.
// When res_stall is high with a result pending, the result is held, one more
// byte waits in the input register, and rx_stall rises.
// -----------------------------------------------------------------------------
// slip_deframer_with_frame_check
// Top level: input register, decoder and result register.
// -----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module slip_deframer_with_frame_check import slp_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              rx_valid,
	output logic                   rx_stall,
	input  wire logic [7:0]        rx_byte,
	output logic                   res_valid,
	input  wire logic              res_stall,
	output logic [1:0]             out_kind,
	output logic [7:0]             data_byte,
	output logic [IDX_W-1:0]       byte_index,
	output logic [IDX_W-1:0]       frame_length,
	output logic [1:0]             frame_class,
	output logic [1:0]             abort_cause
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;
	logic       accept;
	logic       dec_v;
	res_t       dec_res;
	res_t       out_res;

	assign advance  = !res_valid || !res_stall;
	assign rx_stall = valid_s1 && !advance;
	assign accept   = rx_valid && !rx_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (accept)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept)
			byte_s1 <= rx_byte;
	end

	slp_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (valid_s1 && advance),
		.byte_s1 (byte_s1),
		.res_v   (dec_v),
		.res     (dec_res)
	);

	slp_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.res_v     (valid_s1 && dec_v),
		.res       (dec_res),
		.out_valid (res_valid),
		.out_res   (out_res)
	);

	assign out_kind     = out_res.kind;
	assign data_byte    = out_res.data;
	assign byte_index   = out_res.idx;
	assign frame_length = out_res.len;
	assign frame_class  = out_res.cls;
	assign abort_cause  = out_res.cause;

	`ASSERT_NEVER(a_stall_empty, clk, arst_n, rx_stall && !valid_s1)
	`ASSERT_CLK(a_idx_range, clk, arst_n,
		(res_valid && out_kind == KIND_DATA) |-> (byte_index <= IDX_W'(MTU)))
	`ASSERT_CLK(a_commit_len, clk, arst_n,
		(res_valid && out_kind == KIND_COMMIT) |-> (frame_length != '0))
	`ASSERT_NEVER(a_abort_cause, clk, arst_n,
		res_valid && out_kind == KIND_ABORT && abort_cause == CAUSE_NONE)

endmodule

`default_nettype wire
